FILE: rtl/multichannel_motion_debounce_counter_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motion debounce counter unit
// Shared property wrappers, all clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_MOTION_DEBOUNCE_COUNTER_UNIT_MACROS_SVH
`define MULTICHANNEL_MOTION_DEBOUNCE_COUNTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMDC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must never be seen.
`define MMDC_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

FILE: rtl/mmdc_pkg.sv
// ----------------------------------------------------------------------------
// Motion debounce counter package
// Word types, command and register codes, and reset values of the unit.
// ----------------------------------------------------------------------------
package mmdc_pkg;

	// Input line bits carried by one poll word.
	localparam int unsigned LEVEL_W = 8;

	// Command codes.
	localparam logic [1:0] CMD_POLL    = 2'd0;
	localparam logic [1:0] CMD_CONSUME = 2'd1;

	// Configuration register indexes.
	localparam logic [2:0] REG_ACTIVE       = 3'd0;
	localparam logic [2:0] REG_DEBOUNCE     = 3'd1;
	localparam logic [2:0] REG_THRESHOLD    = 3'd2;
	localparam logic [2:0] REG_STUCK_LIMIT  = 3'd3;
	localparam logic [2:0] REG_SEED_LEVELS  = 3'd4;
	localparam logic [2:0] REG_SEED_PRESENT = 3'd5;

	// Register reset values.
	localparam logic [3:0]  RST_ACTIVE      = 4'd0;
	localparam logic [3:0]  RST_DEBOUNCE    = 4'd2;
	localparam logic [7:0]  RST_THRESHOLD   = 8'd3;
	localparam logic [31:0] RST_STUCK_LIMIT = 32'd300000;

	localparam int unsigned DEF_CHANNELS = 8;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  levels;
		logic [31:0] now_ms;
		logic [2:0]  channel;
	} mmdc_in_t;

	typedef struct packed {
		logic        valid_res;
		logic        pending;
		logic [31:0] rise_count;
		logic [31:0] rise_ms;
		logic        present;
		logic        level;
		logic        any_present;
		logic        wedged;
	} mmdc_out_t;

	// Settings shared by every lane.
	typedef struct packed {
		logic [3:0]  debounce;
		logic [7:0]  threshold;
		logic [31:0] stuck_limit;
	} mmdc_cfg_t;

	// Per-lane control for one cycle.
	typedef struct packed {
		logic poll;
		logic clear;
		logic sample;
		logic seed_lvl_we;
		logic seed_lvl;
		logic seed_pres_we;
		logic seed_pres;
	} mmdc_lane_ctl_t;

	// What a lane reports about itself after the current word.
	typedef struct packed {
		logic        level;
		logic        pending;
		logic        present;
		logic        wedged;
		logic [31:0] rise_count;
		logic [31:0] rise_ms;
	} mmdc_lane_res_t;

endpackage

FILE: rtl/multichannel_motion_debounce_counter_unit.sv
// A word accepted at an edge is registered in merge stage one and then in
// stage two, which holds its result word on the output until it is taken.
// Throughput: one word per cycle while the result is not held; every lane
// updates its channel in the accept cycle, and the two merge stages can stall.
// Reset: all channel state clears, registers take their default values;
// no clearing pass, the unit accepts words right after reset.
// ----------------------------------------------------------------------------
// Multichannel motion debounce counter unit
// Top level: configuration registers, one lane per channel, and the merge
// stages that form the result word.
// ----------------------------------------------------------------------------
`include "multichannel_motion_debounce_counter_unit_macros.svh"

module multichannel_motion_debounce_counter_unit #(
	parameter int unsigned CHANNELS = mmdc_pkg::DEF_CHANNELS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mmdc_pkg::mmdc_in_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output mmdc_pkg::mmdc_out_t out_word,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import mmdc_pkg::*;

	logic                active_q;
	logic [3:0]          active_cnt_q;
	logic [3:0]          debounce_q;
	logic [7:0]          threshold_q;
	logic [31:0]         limit_q;
	mmdc_cfg_t           cfg;
	logic                accept;
	logic                chan_ok;
	logic                seed_lvl_we;
	logic                seed_pres_we;
	logic [CHANNELS-1:0] act_mask;
	mmdc_lane_ctl_t      ctl   [CHANNELS];
	mmdc_lane_res_t      lanes [CHANNELS];
	logic                out_invalid;
	logic                chan_zero;
	logic                out_pres_chan;
	logic                wedge_alone;
	logic                out_held;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_cnt_q <= RST_ACTIVE;
			debounce_q   <= RST_DEBOUNCE;
			threshold_q  <= RST_THRESHOLD;
			limit_q      <= RST_STUCK_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE:      active_cnt_q <= cfg_data[3:0];
				REG_DEBOUNCE:    debounce_q   <= cfg_data[3:0];
				REG_THRESHOLD:   threshold_q  <= cfg_data[7:0];
				REG_STUCK_LIMIT: limit_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign active_q     = (active_cnt_q != '0);
	assign cfg          = '{debounce: debounce_q, threshold: threshold_q, stuck_limit: limit_q};
	assign accept       = in_valid && in_ready;
	assign seed_lvl_we  = cfg_we && (cfg_index == REG_SEED_LEVELS);
	assign seed_pres_we = cfg_we && (cfg_index == REG_SEED_PRESENT);
	assign chan_ok      = active_q && (32'(in_word.channel) < 32'(active_cnt_q))
		&& (32'(in_word.channel) < CHANNELS);

	// Per-lane control and the lanes themselves.
	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		logic sample_bit;
		logic seed_lvl_bit;
		logic seed_pres_bit;

		if (i < LEVEL_W) begin : g_pin
			assign sample_bit    = in_word.levels[i];
			assign seed_lvl_bit  = cfg_data[i];
			assign seed_pres_bit = cfg_data[i];
		end else begin : g_nopin
			assign sample_bit    = 1'b0;
			assign seed_lvl_bit  = 1'b0;
			assign seed_pres_bit = 1'b0;
		end

		assign act_mask[i] = (32'(i) < 32'(active_cnt_q));

		always_comb begin
			ctl[i].poll         = accept && (in_word.cmd == CMD_POLL) && act_mask[i];
			ctl[i].clear        = accept && (in_word.cmd == CMD_CONSUME) && chan_ok
				&& (32'(in_word.channel) == 32'(i));
			ctl[i].sample       = sample_bit;
			ctl[i].seed_lvl_we  = seed_lvl_we;
			ctl[i].seed_lvl     = seed_lvl_bit;
			ctl[i].seed_pres_we = seed_pres_we;
			ctl[i].seed_pres    = seed_pres_bit;
		end

		mmdc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl[i]),
			.cfg    (cfg),
			.now_ms (in_word.now_ms),
			.res    (lanes[i])
		);
	end

	// Selection and reduction stages.
	mmdc_merge #(
		.CHANNELS (CHANNELS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.channel   (in_word.channel),
		.chan_ok   (chan_ok),
		.lanes     (lanes),
		.act_mask  (act_mask),
		.ready     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	// Conditions watched by the assertions below.
	assign out_invalid   = out_valid && !out_word.valid_res;
	assign chan_zero     = !out_word.pending && !out_word.present && !out_word.level
		&& (out_word.rise_count == '0) && (out_word.rise_ms == '0);
	assign out_pres_chan = out_valid && out_word.valid_res && out_word.present;
	assign wedge_alone   = out_valid && out_word.wedged && !out_word.any_present;
	assign out_held      = out_valid && !out_ready;

	// An invalid channel reports only the summary flags.
	`MMDC_ASSERT_IMPL(a_invalid_zero, out_invalid, chan_zero, "invalid channel carries data")
	// A present active channel must show up in any_present.
	`MMDC_ASSERT_IMPL(a_present_any, out_pres_chan, out_word.any_present, "present channel missed")
	// Wedged is reported only for a present channel.
	`MMDC_ASSERT_NEVER(a_wedge_present, wedge_alone, "wedged without any present channel")
	// Input stalls only behind a held result.
	`MMDC_ASSERT_IMPL(a_stall_cause, !in_ready, out_held, "input stalled without backpressure")

endmodule

FILE: rtl/mmdc_lane.sv
// ----------------------------------------------------------------------------
// Motion debounce lane
// State and update logic of one channel: debounce, edge count, flags, and
// the wedge check on the updated state.
// ----------------------------------------------------------------------------
module mmdc_lane (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mmdc_pkg::mmdc_lane_ctl_t ctl,
	input  mmdc_pkg::mmdc_cfg_t     cfg,
	input  logic [31:0]             now_ms,
	output mmdc_pkg::mmdc_lane_res_t res
);
	import mmdc_pkg::*;

	logic        lvl_q, lvl_d;
	logic [3:0]  run_q, run_d;
	logic        pend_q, pend_d;
	logic        pres_q, pres_d;
	logic [31:0] cnt_q, cnt_d;
	logic [31:0] last_q, last_d;
	logic [31:0] hs_q, hs_d;
	logic [4:0]  run_inc;
	logic        pend_res;
	logic [31:0] elapsed;

	// Next state of the channel for a poll, a consume or a seed write.
	always_comb begin
		lvl_d   = lvl_q;
		run_d   = run_q;
		pend_d  = pend_q;
		pres_d  = pres_q;
		cnt_d   = cnt_q;
		last_d  = last_q;
		hs_d    = hs_q;
		run_inc = {1'b0, run_q} + 5'd1;
		if (ctl.poll) begin
			if (ctl.sample == lvl_q) begin
				run_d = '0;
			end else if (run_inc < {1'b0, cfg.debounce}) begin
				run_d = run_inc[3:0];
			end else begin
				lvl_d = ctl.sample;
				run_d = '0;
				if (ctl.sample) begin
					hs_d   = now_ms;
					last_d = now_ms;
					cnt_d  = cnt_q + 32'd1;
					pend_d = 1'b1;
					if (cnt_d >= {24'd0, cfg.threshold}) begin
						pres_d = 1'b1;
					end
				end else begin
					hs_d = '0;
				end
			end
		end
		// The result shows pending as it was before a consume clears it.
		pend_res = pend_d;
		if (ctl.clear) begin
			pend_d = 1'b0;
		end
		if (ctl.seed_lvl_we) begin
			lvl_d = ctl.seed_lvl;
			run_d = '0;
			hs_d  = '0;
		end
		if (ctl.seed_pres_we) begin
			pres_d = ctl.seed_pres;
		end
		elapsed = now_ms - hs_d;
	end

	// Report the updated state.
	always_comb begin
		res.level      = lvl_d;
		res.pending    = pend_res;
		res.present    = pres_d;
		res.wedged     = pres_d && lvl_d && (elapsed > cfg.stuck_limit);
		res.rise_count = cnt_d;
		res.rise_ms    = last_d;
	end

	// Channel state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q  <= 1'b0;
			run_q  <= '0;
			pend_q <= 1'b0;
			pres_q <= 1'b0;
			cnt_q  <= '0;
			last_q <= '0;
			hs_q   <= '0;
		end else begin
			lvl_q  <= lvl_d;
			run_q  <= run_d;
			pend_q <= pend_d;
			pres_q <= pres_d;
			cnt_q  <= cnt_d;
			last_q <= last_d;
			hs_q   <= hs_d;
		end
	end

endmodule

FILE: rtl/mmdc_merge.sv
// ----------------------------------------------------------------------------
// Motion debounce lane merge
// Picks the addressed lane, masks flags by the active set, then reduces
// them into any_present and wedged in a second stage that holds the result.
// ----------------------------------------------------------------------------
module mmdc_merge #(
	parameter int unsigned CHANNELS = mmdc_pkg::DEF_CHANNELS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic [2:0]               channel,
	input  logic                     chan_ok,
	input  mmdc_pkg::mmdc_lane_res_t lanes [CHANNELS],
	input  logic [CHANNELS-1:0]      act_mask,
	output logic                     ready,
	output logic                     out_valid,
	input  logic                     out_ready,
	output mmdc_pkg::mmdc_out_t      out_word
);
	import mmdc_pkg::*;

	mmdc_lane_res_t      sel;
	logic [CHANNELS-1:0] pres_vec;
	logic [CHANNELS-1:0] wedge_vec;
	logic                v_s1;
	logic                ok_s1;
	mmdc_lane_res_t      sel_s1;
	logic [CHANNELS-1:0] pres_s1;
	logic [CHANNELS-1:0] wedge_s1;
	logic                adv2;
	logic                out_v_q;
	mmdc_out_t           out_q;

	// Select the addressed lane and mask inactive lanes.
	always_comb begin
		sel = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (32'(channel) == 32'(i)) begin
				sel = lanes[i];
			end
			pres_vec[i]  = act_mask[i] && lanes[i].present;
			wedge_vec[i] = act_mask[i] && lanes[i].wedged;
		end
	end

	// Handshake of the two stages.
	assign adv2      = !out_v_q || out_ready;
	assign ready     = !v_s1 || adv2;
	assign out_valid = out_v_q;
	assign out_word  = out_q;

	// Stage one: selected lane and masked flag vectors.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load) begin
			v_s1 <= 1'b1;
		end else if (adv2) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ok_s1    <= chan_ok;
			sel_s1   <= chan_ok ? sel : '0;
			pres_s1  <= pres_vec;
			wedge_s1 <= wedge_vec;
		end
	end

	// Stage two: reduced flags and the held output word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv2) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			out_q.valid_res   <= ok_s1;
			out_q.pending     <= sel_s1.pending;
			out_q.rise_count  <= sel_s1.rise_count;
			out_q.rise_ms     <= sel_s1.rise_ms;
			out_q.present     <= sel_s1.present;
			out_q.level       <= sel_s1.level;
			out_q.any_present <= |pres_s1;
			out_q.wedged      <= |wedge_s1;
		end
	end

endmodule
